FILE: hdl/stereo_sample_histogram_top_macros.svh
// Assertion helpers used by the checks in the top-level module.
`ifndef STEREO_SAMPLE_HISTOGRAM_TOP_MACROS_SVH
`define STEREO_SAMPLE_HISTOGRAM_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ssh_pkg.sv
package ssh_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int IN_BITS         = 16;
  localparam int OUT_BITS        = 32;

  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic acc;
    logic bump;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } status_t;

endpackage

FILE: hdl/stereo_sample_histogram_top.sv
// Channel  Direction  Ports
// in_      input      in_valid, in_stall, in_action, in_left_sample, in_right_sample,
//                     in_query_value
// out_     output     out_valid, out_stall, out_left_count, out_right_count, out_mono_count
//
// Each transaction is one RAM read, then the saturating write or the result
// capture; no new transaction is taken until it is through.
// After reset a clearing pass zeroes all 2**SAMPLE_BITS bins (65536 by default);
// no input transaction is taken until it ends.
// A read transaction waits while the held result is stalled.
`include "stereo_sample_histogram_top_macros.svh"

module stereo_sample_histogram_top #(
  parameter int SAMPLE_BITS = ssh_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = ssh_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic signed [ssh_pkg::IN_BITS-1:0] in_left_sample,
  input  logic signed [ssh_pkg::IN_BITS-1:0] in_right_sample,
  input  logic signed [ssh_pkg::IN_BITS-1:0] in_query_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ssh_pkg::OUT_BITS-1:0]       out_left_count,
  output logic [ssh_pkg::OUT_BITS-1:0]       out_right_count,
  output logic [ssh_pkg::OUT_BITS-1:0]       out_mono_count
);

  ssh_pkg::cmd_t    cmd;
  ssh_pkg::status_t status;
  logic             acc_count;
  logic             acc_read;

  ssh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ssh_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_action       (in_action),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_query_value  (in_query_value),
    .out_left_count  (out_left_count),
    .out_right_count (out_right_count),
    .out_mono_count  (out_mono_count)
  );

  assign acc_count = cmd.acc && (in_action == ssh_pkg::ACT_COUNT);
  assign acc_read  = cmd.acc && (in_action == ssh_pkg::ACT_READ);

  `SSH_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, cmd.clr_wr, in_stall, "transaction taken during clear")
  `SSH_ASSERT_NEXT(a_bump_after_accept, clk, rst_n, acc_count, cmd.bump, "count not written back")
  `SSH_ASSERT_NOW(a_read_gives_result, clk, rst_n, acc_read, ##2 out_valid, "read result missing")
  `SSH_ASSERT_NOW(a_capture_after_read, clk, rst_n, cmd.capture, $past(cmd.acc) && !out_valid, "capture without read")

endmodule

FILE: hdl/ssh_ram.sv
module ssh_ram #(
  parameter int WIDTH = ssh_pkg::COUNT_BITS_DEF,
  parameter int DEPTH = 2 ** ssh_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/ssh_ctrl.sv
module ssh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ssh_pkg::status_t status,
  output ssh_pkg::cmd_t    cmd
);

  ssh_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            acc;

  // stall while clearing or busy, and hold off a read transaction while the result transaction is held
  assign in_stall = (state_r != ssh_pkg::ST_IDLE) ||
                    ((in_action == ssh_pkg::ACT_READ) && out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ssh_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_done) begin
          state_nxt = ssh_pkg::ST_IDLE;
        end
      end
      ssh_pkg::ST_IDLE: begin
        cmd.acc = acc;
        if (acc) begin
          state_nxt = (in_action == ssh_pkg::ACT_READ) ? ssh_pkg::ST_READ : ssh_pkg::ST_COUNT;
        end
      end
      ssh_pkg::ST_COUNT: begin
        cmd.bump  = 1'b1;
        state_nxt = ssh_pkg::ST_IDLE;
      end
      ssh_pkg::ST_READ: begin
        cmd.capture   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ssh_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ssh_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssh_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/ssh_datapath.sv
module ssh_datapath #(
  parameter int SAMPLE_BITS = ssh_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = ssh_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssh_pkg::cmd_t                       cmd,
  output ssh_pkg::status_t                    status,
  input  logic                                in_action,
  input  logic signed [ssh_pkg::IN_BITS-1:0]  in_left_sample,
  input  logic signed [ssh_pkg::IN_BITS-1:0]  in_right_sample,
  input  logic signed [ssh_pkg::IN_BITS-1:0]  in_query_value,
  output logic [ssh_pkg::OUT_BITS-1:0]        out_left_count,
  output logic [ssh_pkg::OUT_BITS-1:0]        out_right_count,
  output logic [ssh_pkg::OUT_BITS-1:0]        out_mono_count
);

  localparam int SB    = SAMPLE_BITS;
  localparam int OB    = ssh_pkg::OUT_BITS;
  localparam int DEPTH = 2 ** SB;

  logic [SB-1:0]         l_idx, r_idx, q_idx, m_idx;
  logic signed [SB:0]    sum, sum_adj;
  logic [SB-1:0]         l_raddr, r_raddr, m_raddr;
  logic [SB-1:0]         l_idx_r, r_idx_r, m_idx_r;
  logic [SB-1:0]         l_idx_nxt, r_idx_nxt, m_idx_nxt;
  logic [SB-1:0]         clr_addr_r, clr_addr_nxt;
  logic [SB-1:0]         l_waddr, r_waddr, m_waddr;
  logic                  we;
  logic [COUNT_BITS-1:0] l_rd, r_rd, m_rd;
  logic [COUNT_BITS-1:0] l_wd, r_wd, m_wd;
  logic [OB-1:0]         l_cnt_r, r_cnt_r, m_cnt_r;
  logic [OB-1:0]         l_cnt_nxt, r_cnt_nxt, m_cnt_nxt;

  assign l_idx = in_left_sample[SB-1:0];
  assign r_idx = in_right_sample[SB-1:0];
  assign q_idx = in_query_value[SB-1:0];

  // halve the pair sum, truncating toward zero
  assign sum     = $signed({l_idx[SB-1], l_idx}) + $signed({r_idx[SB-1], r_idx});
  assign sum_adj = sum + $signed({{SB{1'b0}}, sum[SB]});
  assign m_idx   = sum_adj[SB:1];

  assign l_raddr = (in_action == ssh_pkg::ACT_READ) ? q_idx : l_idx;
  assign r_raddr = (in_action == ssh_pkg::ACT_READ) ? q_idx : r_idx;
  assign m_raddr = (in_action == ssh_pkg::ACT_READ) ? q_idx : m_idx;

  assign l_idx_nxt = cmd.acc ? l_idx : l_idx_r;
  assign r_idx_nxt = cmd.acc ? r_idx : r_idx_r;
  assign m_idx_nxt = cmd.acc ? m_idx : m_idx_r;

  assign clr_addr_nxt    = cmd.clr_wr ? clr_addr_r + 1'b1 : clr_addr_r;
  assign status.clr_done = &clr_addr_r;

  assign we      = cmd.clr_wr || cmd.bump;
  assign l_waddr = cmd.clr_wr ? clr_addr_r : l_idx_r;
  assign r_waddr = cmd.clr_wr ? clr_addr_r : r_idx_r;
  assign m_waddr = cmd.clr_wr ? clr_addr_r : m_idx_r;

  // write zero while clearing, else count up and saturate at full scale
  assign l_wd = cmd.clr_wr ? '0 : ((&l_rd) ? l_rd : l_rd + COUNT_BITS'(1));
  assign r_wd = cmd.clr_wr ? '0 : ((&r_rd) ? r_rd : r_rd + COUNT_BITS'(1));
  assign m_wd = cmd.clr_wr ? '0 : ((&m_rd) ? m_rd : m_rd + COUNT_BITS'(1));

  assign l_cnt_nxt = cmd.capture ? OB'(l_rd) : l_cnt_r;
  assign r_cnt_nxt = cmd.capture ? OB'(r_rd) : r_cnt_r;
  assign m_cnt_nxt = cmd.capture ? OB'(m_rd) : m_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_idx_r <= l_idx_nxt;
    r_idx_r <= r_idx_nxt;
    m_idx_r <= m_idx_nxt;
    l_cnt_r <= l_cnt_nxt;
    r_cnt_r <= r_cnt_nxt;
    m_cnt_r <= m_cnt_nxt;
  end

  ssh_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (we),
    .waddr (l_waddr),
    .wdata (l_wd),
    .raddr (l_raddr),
    .rdata (l_rd)
  );

  ssh_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (we),
    .waddr (r_waddr),
    .wdata (r_wd),
    .raddr (r_raddr),
    .rdata (r_rd)
  );

  ssh_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_mono_ram (
    .clk   (clk),
    .we    (we),
    .waddr (m_waddr),
    .wdata (m_wd),
    .raddr (m_raddr),
    .rdata (m_rd)
  );

  assign out_left_count  = l_cnt_r;
  assign out_right_count = r_cnt_r;
  assign out_mono_count  = m_cnt_r;

endmodule

FILE: tb/sv/stereo_sample_histogram_top_tb.sv
module stereo_sample_histogram_top_tb;

  typedef logic signed [ssh_pkg::IN_BITS-1:0] sample_t;
  typedef logic [ssh_pkg::OUT_BITS-1:0] count_t;

  typedef struct {
    count_t left;
    count_t right;
    count_t mono;
  } bin_counts_t;

  localparam logic [1:0] CH_LEFT  = 2'd0;
  localparam logic [1:0] CH_RIGHT = 2'd1;
  localparam logic [1:0] CH_MONO  = 2'd2;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 1880;

  class bin_tally_board;
    count_t tally[bit [17:0]];
    bin_counts_t owed_counts[$];
    int unsigned failures;

    function sample_t mono_of(sample_t l, sample_t r);
      int sum;
      sum = int'(l) + int'(r);
      return sample_t'(sum / 2);
    endfunction

    function count_t level(logic [1:0] chan, sample_t v);
      bit [17:0] key;
      key = {chan, v};
      return tally.exists(key) ? tally[key] : '0;
    endfunction

    function void bump(logic [1:0] chan, sample_t v);
      count_t c;
      c = level(chan, v);
      if (c != '1) tally[{chan, v}] = c + 1'b1;
    endfunction

    function void absorb(logic act, sample_t l, sample_t r, sample_t q);
      bin_counts_t exp_counts;
      if (act == ssh_pkg::ACT_COUNT) begin
        bump(CH_LEFT, l);
        bump(CH_RIGHT, r);
        bump(CH_MONO, mono_of(l, r));
      end else begin
        exp_counts.left  = level(CH_LEFT, q);
        exp_counts.right = level(CH_RIGHT, q);
        exp_counts.mono  = level(CH_MONO, q);
        owed_counts = {owed_counts, exp_counts};
      end
    endfunction

    function void compare_counts(count_t lc, count_t rc, count_t mc);
      bin_counts_t exp_counts;
      if (owed_counts.size() == 0) begin
        $error("unexpected result: left_count %0d right_count %0d mono_count %0d",
               lc, rc, mc);
        failures++;
        return;
      end
      exp_counts = owed_counts.pop_front();
      if (lc !== exp_counts.left) begin
        $error("left_count: expected %0d, actual %0d", exp_counts.left, lc);
        failures++;
      end
      if (rc !== exp_counts.right) begin
        $error("right_count: expected %0d, actual %0d", exp_counts.right, rc);
        failures++;
      end
      if (mc !== exp_counts.mono) begin
        $error("mono_count: expected %0d, actual %0d", exp_counts.mono, mc);
        failures++;
      end
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  logic    in_action;
  sample_t in_left_sample;
  sample_t in_right_sample;
  sample_t in_query_value;
  logic    out_valid;
  logic    out_stall;
  count_t  out_left_count;
  count_t  out_right_count;
  count_t  out_mono_count;

  bin_tally_board board = new();
  bit calm;
  bit hold_req;
  int unsigned quiet_cycles;
  sample_t hot_values[8] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1,
                             16'sd1, 16'sd2, -16'sd2, 16'sd100};
  sample_t recent_values[$];

  stereo_sample_histogram_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_left_sample (in_left_sample),
    .in_right_sample(in_right_sample),
    .in_query_value (in_query_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_count (out_left_count),
    .out_right_count(out_right_count),
    .out_mono_count (out_mono_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sample_t pick_sample();
    if ($urandom_range(0, 99) < 60) return hot_values[$urandom_range(0, 7)];
    return sample_t'($urandom);
  endfunction

  task automatic send_item(logic act, sample_t l, sample_t r, sample_t q);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_left_sample  <= l;
    in_right_sample <= r;
    in_query_value  <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic count_pair(sample_t l, sample_t r);
    send_item(ssh_pkg::ACT_COUNT, l, r, sample_t'($urandom));
  endtask

  task automatic read_bins(sample_t q);
    send_item(ssh_pkg::ACT_READ, sample_t'($urandom), sample_t'($urandom), q);
  endtask

  // hold off the result channel on request, otherwise stall at random outside the calm stretch
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 6);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.absorb(in_action, in_left_sample, in_right_sample, in_query_value);
    if (rst_n && out_valid && !out_stall)
      board.compare_counts(out_left_count, out_right_count, out_mono_count);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stereo_sample_histogram_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_t l;
    sample_t r;
    sample_t q;
    calm            = 1'b0;
    hold_req        = 1'b0;
    quiet_cycles    = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= ssh_pkg::ACT_COUNT;
    in_left_sample  <= '0;
    in_right_sample <= '0;
    in_query_value  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    count_pair(-16'sd32768, -16'sd32768);
    count_pair(16'sd32767, 16'sd32767);
    count_pair(-16'sd32768, 16'sd32767);
    count_pair(-16'sd1, 16'sd0);
    count_pair(-16'sd3, 16'sd0);
    count_pair(16'sd3, 16'sd0);
    count_pair(16'sd0, -16'sd1);
    read_bins(-16'sd32768);
    read_bins(16'sd32767);
    read_bins(16'sd0);
    read_bins(-16'sd1);
    read_bins(16'sd1);
    read_bins(-16'sd2);
    read_bins(16'sd12345);
    count_pair(16'sd32767, -16'sd32768);
    count_pair(-16'sd32767, -16'sd32768);
    read_bins(-16'sd32767);
    read_bins(-16'sd32768);
    count_pair(16'sd21845, -16'sd21846);
    read_bins(16'sd21845);
    read_bins(-16'sd21846);
    read_bins(16'sd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 300 && n < 800);
      if (n == 1200) hold_req = 1'b1;
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 99) < 70 && recent_values.size() != 0)
          q = recent_values[$urandom_range(0, recent_values.size() - 1)];
        else
          q = pick_sample();
        read_bins(q);
      end else begin
        l = pick_sample();
        r = pick_sample();
        recent_values = {recent_values, l, r, board.mono_of(l, r)};
        while (recent_values.size() > 64) void'(recent_values.pop_front());
        count_pair(l, r);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.owed_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.owed_counts.size() == 0)
      $display("stereo_sample_histogram_top regression: pass");
    else
      $display("stereo_sample_histogram_top regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ssh_pkg.sv
hdl/ssh_ram.sv
hdl/ssh_ctrl.sv
hdl/ssh_datapath.sv
hdl/stereo_sample_histogram_top.sv
tb/sv/stereo_sample_histogram_top_tb.sv
